// ===== rtl/pli_pkg.sv =====
`timescale 1ns / 1ps

package pli_pkg;

    // List capacity, clipped to what the store and the result fields can hold.
    localparam int CAPACITY  = 16;
    localparam int MAX_CELLS = 16;
    localparam int EFF_CAP   = (CAPACITY < MAX_CELLS) ? CAPACITY : MAX_CELLS;

    localparam int OP_W    = 2;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 5;
    localparam int STAT_W  = 3;
    localparam int IDX_W   = 4;
    localparam int TOTAL_W = 5;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT   = 2'd0,
        OP_DELETE   = 2'd1,
        OP_TRAVERSE = 2'd2
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE    = 3'd0,
        ST_BAD_POS = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_FULL    = 3'd3,
        ST_ELEMENT = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_INSERT,
        CMD_DELETE,
        CMD_ROTATE
    } cell_cmd_t;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        cell_cmd_t          cmd;
        logic [POS_W-1:0]   pos;
        logic [TOTAL_W-1:0] last_pos;
    } cell_ctrl_t;

    typedef struct packed {
        logic [OP_W-1:0]           operation;
        logic signed [VALUE_W-1:0] item_value;
        logic [POS_W-1:0]          slot_index;
    } in_item_t;

    typedef struct packed {
        logic [STAT_W-1:0]         status;
        logic signed [VALUE_W-1:0] element_value;
        logic [IDX_W-1:0]          element_index;
        logic [TOTAL_W-1:0]        element_total;
        logic                      last;
    } out_item_t;

endpackage

// ===== rtl/pli_cell.sv =====
`timescale 1ns / 1ps

module pli_cell (
    input  logic                                aclk,
    input  pli_pkg::cell_ctrl_t                 ctrl,
    input  logic [pli_pkg::TOTAL_W-1:0]         cell_idx,
    input  logic signed [pli_pkg::VALUE_W-1:0]  new_value,
    input  logic signed [pli_pkg::VALUE_W-1:0]  left_value,
    input  logic signed [pli_pkg::VALUE_W-1:0]  right_value,
    input  logic signed [pli_pkg::VALUE_W-1:0]  wrap_value,
    output logic signed [pli_pkg::VALUE_W-1:0]  value
);
    import pli_pkg::*;

    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;

    always_comb begin
        value_next = value_reg;
        case (ctrl.cmd)
            CMD_INSERT: begin
                // Open a gap at the position, shift later cells up.
                if (cell_idx == ctrl.pos) begin
                    value_next = new_value;
                end else if (cell_idx > ctrl.pos) begin
                    value_next = left_value;
                end
            end
            CMD_DELETE: begin
                // Close the gap, shift later cells down.
                if (cell_idx >= ctrl.pos) begin
                    value_next = right_value;
                end
            end
            CMD_ROTATE: begin
                // Advance the list toward cell 0, the head wraps to the tail.
                if (cell_idx == ctrl.last_pos) begin
                    value_next = wrap_value;
                end else begin
                    value_next = right_value;
                end
            end
            default: begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// ===== rtl/positional_list_insert_delete.sv =====
`timescale 1ns / 1ps

// Channel  Ports                      Payload             Direction
// s_       s_valid s_ready s_data     pli_pkg::in_item_t  operation beat in
// m_       m_valid m_ready m_data     pli_pkg::out_item_t result beat out
//
// Insert and delete answer one beat each; all cells shift at once.
// Traverse first starts the walk, then gives one element beat per cycle while the
// result register is free, rotating the cell chain one place per beat; after the last
// beat the list is back in place.
// Reset (aresetn low at a clock edge) empties the list; cell contents are not cleared.
// A stall on m_ready holds the result register and pauses any traversal.
// A new operation is taken when no traversal runs and the result register is free.

module positional_list_insert_delete (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  pli_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output pli_pkg::out_item_t m_data
);
    import pli_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_TRAV
    } state_t;

    state_t             state_reg,    state_next;
    logic [TOTAL_W-1:0] count_reg,    count_next;
    logic [IDX_W-1:0]   trav_idx_reg, trav_idx_next;
    logic               m_valid_reg,  m_valid_next;
    out_item_t          m_data_reg,   m_data_next;

    cell_ctrl_t                ctrl;
    logic signed [VALUE_W-1:0] cell_value [EFF_CAP];

    logic               out_free;
    logic               s_fire;
    logic [TOTAL_W-1:0] last_pos;
    logic               trav_last;

    // Output slot frees when empty or being taken this cycle.
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE) && out_free;
    assign s_fire   = s_valid && s_ready;

    assign last_pos  = count_reg - TOTAL_W'(1);
    assign trav_last = ({1'b0, trav_idx_reg} == last_pos);

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        trav_idx_next = trav_idx_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        ctrl.cmd      = CMD_HOLD;
        ctrl.pos      = s_data.slot_index;
        ctrl.last_pos = last_pos;

        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    m_data_next.element_value = '0;
                    m_data_next.element_index = '0;
                    m_data_next.last          = 1'b1;
                    case (s_data.operation)
                        OP_INSERT: begin
                            if (s_data.slot_index > count_reg) begin
                                m_data_next.status = ST_BAD_POS;
                            end else if (count_reg >= TOTAL_W'(EFF_CAP)) begin
                                m_data_next.status = ST_FULL;
                            end else begin
                                m_data_next.status = ST_DONE;
                                ctrl.cmd           = CMD_INSERT;
                                count_next         = count_reg + TOTAL_W'(1);
                            end
                            m_data_next.element_total = count_next;
                            m_valid_next              = 1'b1;
                        end
                        OP_DELETE: begin
                            if (count_reg == '0) begin
                                m_data_next.status = ST_EMPTY;
                            end else if (s_data.slot_index >= count_reg) begin
                                m_data_next.status = ST_BAD_POS;
                            end else begin
                                m_data_next.status = ST_DONE;
                                ctrl.cmd           = CMD_DELETE;
                                count_next         = count_reg - TOTAL_W'(1);
                            end
                            m_data_next.element_total = count_next;
                            m_valid_next              = 1'b1;
                        end
                        OP_TRAVERSE: begin
                            if (count_reg == '0) begin
                                m_data_next.status        = ST_EMPTY;
                                m_data_next.element_total = '0;
                                m_valid_next              = 1'b1;
                            end else begin
                                // Start the walk; the first beat is built in S_TRAV and then registered.
                                state_next    = S_TRAV;
                                trav_idx_next = '0;
                            end
                        end
                        default: begin
                            // Unused code: drop the beat, no result.
                            m_data_next = m_data_reg;
                        end
                    endcase
                end
            end
            S_TRAV: begin
                if (out_free) begin
                    // Emit the head cell and rotate the chain by one.
                    m_data_next.status        = ST_ELEMENT;
                    m_data_next.element_value = cell_value[0];
                    m_data_next.element_index = trav_idx_reg;
                    m_data_next.element_total = count_reg;
                    m_data_next.last          = trav_last;
                    m_valid_next              = 1'b1;
                    ctrl.cmd                  = CMD_ROTATE;
                    trav_idx_next             = trav_idx_reg + IDX_W'(1);
                    if (trav_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            trav_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            trav_idx_reg <= trav_idx_next;
            m_valid_reg  <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Each cell sees its neighbors and the head; cell 0 takes the input from its left.
    for (genvar g = 0; g < EFF_CAP; g++) begin : g_cell
        logic signed [VALUE_W-1:0] left_value;
        logic signed [VALUE_W-1:0] right_value;

        if (g == 0) begin : g_head
            assign left_value = s_data.item_value;
        end else begin : g_body
            assign left_value = cell_value[g-1];
        end

        if (g == EFF_CAP - 1) begin : g_tail
            assign right_value = cell_value[g];
        end else begin : g_inner
            assign right_value = cell_value[g+1];
        end

        pli_cell u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .cell_idx    (TOTAL_W'(g)),
            .new_value   (s_data.item_value),
            .left_value  (left_value),
            .right_value (right_value),
            .wrap_value  (cell_value[0]),
            .value       (cell_value[g])
        );
    end

    // The count never passes the capacity.
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= TOTAL_W'(EFF_CAP))
        else $error("element count above capacity");

    // A traversal only runs over a non-empty list and stays in range.
    a_trav_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_TRAV |-> (count_reg != '0) && ({1'b0, trav_idx_reg} < count_reg))
        else $error("traversal index out of range");

    // The count does not change during a traversal.
    a_trav_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_TRAV |=> count_reg == $past(count_reg))
        else $error("count changed during traversal");

    // A successful insert grows the list by exactly one.
    a_insert_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && (s_data.operation == OP_INSERT) && (ctrl.cmd == CMD_INSERT)
        |=> count_reg == $past(count_reg) + TOTAL_W'(1))
        else $error("insert did not grow the list by one");

    // A result beat marked last leaves no traversal running behind it.
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_TRAV) && out_free && trav_last |=> state_reg == S_IDLE)
        else $error("traversal continued past last element");

endmodule
